/* src/esaw_pkg.sv */
package esaw_pkg;

  localparam int SLICE_COUNT     = 4;
  localparam int COLUMNS         = 256;
  localparam int ROWS            = 256;
  localparam int PIXELS_PER_WORD = 32;
  localparam int PIXEL_BITS      = 4;
  localparam int WINDOW_LEN      = 11;

  localparam int WORDS_PER_COL = (ROWS + PIXELS_PER_WORD - 1) / PIXELS_PER_WORD;
  localparam int WORD_W        = PIXELS_PER_WORD * PIXEL_BITS;
  localparam int SLICE_BITS    = $clog2(SLICE_COUNT);
  localparam int COL_BITS      = 8;
  localparam int ROW_BITS      = 8;
  localparam int OFF_BITS      = $clog2(PIXELS_PER_WORD);
  localparam int WORD_BITS     = ROW_BITS - OFF_BITS;
  localparam int ADDR_W        = COL_BITS + WORD_BITS;
  localparam int MEM_DEPTH     = 1 << ADDR_W;
  localparam int IDX_W         = $clog2(WINDOW_LEN + 1);
  localparam int WIN_PIX_BITS  = OFF_BITS + 1;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [IDX_W-1:0]  idx_t;

  typedef struct packed {
    logic [COL_BITS-1:0]   event_x;
    logic [ROW_BITS-1:0]   event_y;
    logic [SLICE_BITS-1:0] active_slice;
  } event_t;

  typedef struct packed {
    logic [3:0]            window_pos;
    logic [PIXEL_BITS-1:0] ref_pixel;
    logic [PIXEL_BITS-1:0] tag_pixel;
    logic                  last;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic  accept;
    logic  rd_next;
    logic  cap_hi;
    logic  cap_lo;
    logic  wr_upd;
    logic  clr_wr;
    addr_t clr_addr;
    logic  load_out;
    idx_t  win_idx;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } dp_stat_t;

endpackage

/* src/esaw_dp.sv */
module esaw_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  esaw_pkg::event_t    in_data_i,
  input  esaw_pkg::ctrl_cmd_t cmd_i,
  output esaw_pkg::dp_stat_t  stat_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output esaw_pkg::result_t   out_data_o
);

  localparam int ALL_W = esaw_pkg::SLICE_COUNT * esaw_pkg::WORD_W;

  // Latched event.
  logic [esaw_pkg::COL_BITS-1:0]   x_q;
  logic [esaw_pkg::WORD_BITS-1:0]  w_q;
  logic [esaw_pkg::OFF_BITS-1:0]   off_q;
  logic [esaw_pkg::SLICE_BITS-1:0] s_q;
  logic                            ev_ok_q;
  logic                            ev_ok;

  // Captured words: the word to increment and both halves of the windows.
  esaw_pkg::word_t inc_q, ref_hi_q, tag_hi_q, ref_lo_q, tag_lo_q;
  esaw_pkg::word_t inc_word;

  logic [ALL_W-1:0]   rd_all;
  logic [2*ALL_W-1:0] rd_shift;
  logic [ALL_W-1:0]   rd_rot;
  esaw_pkg::word_t    rd_cur, rd_ref, rd_tag;

  esaw_pkg::addr_t rd_addr, wr_addr;
  logic [esaw_pkg::SLICE_BITS-1:0] s_clr;
  logic            last_word;

  logic                                out_valid_q;
  esaw_pkg::result_t                   out_q;
  logic [esaw_pkg::WIN_PIX_BITS-1:0]   pix_idx;
  logic [2*esaw_pkg::WORD_W-1:0]       ref_dw, tag_dw;
  logic [esaw_pkg::PIXEL_BITS-1:0]     ref_pix, tag_pix;

  assign ev_ok = ({1'b0, in_data_i.event_x} < (esaw_pkg::COL_BITS+1)'(esaw_pkg::COLUMNS)) &&
                 ({1'b0, in_data_i.event_y} < (esaw_pkg::ROW_BITS+1)'(esaw_pkg::ROWS));

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      x_q     <= in_data_i.event_x;
      w_q     <= in_data_i.event_y[esaw_pkg::ROW_BITS-1:esaw_pkg::OFF_BITS];
      off_q   <= in_data_i.event_y[esaw_pkg::OFF_BITS-1:0];
      s_q     <= in_data_i.active_slice;
      ev_ok_q <= ev_ok;
    end
  end

  assign s_clr     = esaw_pkg::SLICE_BITS'(s_q + esaw_pkg::SLICE_BITS'(3));
  assign last_word = (w_q == esaw_pkg::WORD_BITS'(esaw_pkg::WORDS_PER_COL - 1));

  // At acceptance the word holding y is read straight from the input;
  // afterwards the following word of the column is read.
  assign rd_addr = cmd_i.rd_next ?
                   {x_q, esaw_pkg::WORD_BITS'(w_q + esaw_pkg::WORD_BITS'(1))} :
                   {in_data_i.event_x,
                    in_data_i.event_y[esaw_pkg::ROW_BITS-1:esaw_pkg::OFF_BITS]};
  assign wr_addr = cmd_i.clr_wr ? cmd_i.clr_addr : {x_q, w_q};

  always_comb begin
    inc_word = inc_q;
    inc_word[{off_q, 2'b00} +: esaw_pkg::PIXEL_BITS] =
      inc_q[{off_q, 2'b00} +: esaw_pkg::PIXEL_BITS] + esaw_pkg::PIXEL_BITS'(1);
  end

  for (genvar k = 0; k < esaw_pkg::SLICE_COUNT; k++) begin : g_slice
    esaw_pkg::word_t mem [esaw_pkg::MEM_DEPTH];
    esaw_pkg::word_t rdata_q;
    logic            wr_en;
    esaw_pkg::word_t wr_data;

    assign wr_en = cmd_i.clr_wr ||
                   (cmd_i.wr_upd && ev_ok_q &&
                    ((s_q == esaw_pkg::SLICE_BITS'(k)) || (s_clr == esaw_pkg::SLICE_BITS'(k))));
    assign wr_data = (!cmd_i.clr_wr && (s_q == esaw_pkg::SLICE_BITS'(k))) ? inc_word : '0;

    always_ff @(posedge clk_i) begin
      if (wr_en) begin
        mem[wr_addr] <= wr_data;
      end
      rdata_q <= mem[rd_addr];
    end

    assign rd_all[k*esaw_pkg::WORD_W +: esaw_pkg::WORD_W] = rdata_q;
  end

  // Rotate the slices so that the active one lands in the lowest position.
  assign rd_shift = {rd_all, rd_all} >> (esaw_pkg::WORD_W * int'(s_q));
  assign rd_rot   = rd_shift[ALL_W-1:0];
  assign rd_cur   = rd_rot[0 +: esaw_pkg::WORD_W];
  assign rd_ref   = rd_rot[esaw_pkg::WORD_W +: esaw_pkg::WORD_W];
  assign rd_tag   = rd_rot[2*esaw_pkg::WORD_W +: esaw_pkg::WORD_W];

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_hi) begin
      inc_q    <= rd_cur;
      ref_hi_q <= rd_ref;
      tag_hi_q <= rd_tag;
    end
    if (cmd_i.cap_lo) begin
      ref_lo_q <= last_word ? '0 : rd_ref;
      tag_lo_q <= last_word ? '0 : rd_tag;
    end
  end

  assign pix_idx = esaw_pkg::WIN_PIX_BITS'({1'b0, off_q} +
                                           esaw_pkg::WIN_PIX_BITS'(cmd_i.win_idx));
  assign ref_dw  = {ref_hi_q, ref_lo_q};
  assign tag_dw  = {tag_hi_q, tag_lo_q};
  assign ref_pix = ev_ok_q ? ref_dw[{pix_idx, 2'b00} +: esaw_pkg::PIXEL_BITS] : '0;
  assign tag_pix = ev_ok_q ? tag_dw[{pix_idx, 2'b00} +: esaw_pkg::PIXEL_BITS] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.window_pos <= 4'(cmd_i.win_idx);
      out_q.ref_pixel  <= ref_pix;
      out_q.tag_pixel  <= tag_pix;
      out_q.last       <= (cmd_i.win_idx == esaw_pkg::IDX_W'(esaw_pkg::WINDOW_LEN - 1));
    end
  end

  assign stat_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_q;

endmodule

/* src/esaw_ctrl.sv */
module esaw_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  esaw_pkg::dp_stat_t  stat_i,
  output esaw_pkg::ctrl_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH,
    ST_UPDATE,
    ST_EMIT
  } state_e;

  state_e          state_q;
  esaw_pkg::addr_t clr_cnt_q;
  esaw_pkg::idx_t  idx_q;
  logic            idx_last;

  assign idx_last   = (idx_q == esaw_pkg::IDX_W'(esaw_pkg::WINDOW_LEN - 1));
  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    cmd_o          = '0;
    cmd_o.clr_addr = clr_cnt_q;
    cmd_o.win_idx  = idx_q;
    unique case (state_q)
      ST_CLEAR:  cmd_o.clr_wr = 1'b1;
      ST_IDLE:   cmd_o.accept = in_valid_i;
      ST_FETCH: begin
        cmd_o.rd_next = 1'b1;
        cmd_o.cap_hi  = 1'b1;
      end
      ST_UPDATE: begin
        cmd_o.rd_next = 1'b1;
        cmd_o.cap_lo  = 1'b1;
        cmd_o.wr_upd  = 1'b1;
      end
      ST_EMIT: begin
        cmd_o.rd_next  = 1'b1;
        cmd_o.load_out = stat_i.out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
      idx_q     <= '0;
    end else begin
      unique case (state_q)
        ST_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + esaw_pkg::ADDR_W'(1);
          if (clr_cnt_q == esaw_pkg::ADDR_W'(esaw_pkg::MEM_DEPTH - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_FETCH;
          end
        end
        ST_FETCH: state_q <= ST_UPDATE;
        ST_UPDATE: begin
          idx_q   <= '0;
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (stat_i.out_free) begin
            idx_q <= idx_q + esaw_pkg::IDX_W'(1);
            if (idx_last) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_CLEAR;
      endcase
    end
  end

  // A result is loaded only into a free output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> stat_i.out_free)
    else $error("result loaded into an occupied output register");

  // The slice memories are never cleared while an event is being taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.clr_wr && cmd_o.accept))
    else $error("event accepted during the clearing pass");

  // The read-modify-write always follows the capture of the event's word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.wr_upd |-> $past(cmd_o.cap_hi))
    else $error("slice update without a captured word");

  // After the final window result the block is ready for the next event.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.load_out && idx_last) |=> !in_stall_o)
    else $error("block not ready after the last window result");

endmodule

/* src/event_slice_accumulate_window_read.sv */
// After acceptance the controller passes through FETCH and UPDATE; in EMIT the first window
// result is loaded once the output register is free, and the remaining results follow one per
// cycle while the output is not stalled. A new event is taken only in the idle state, after all
// eleven results of the last one have gone into the single output register that reads them out.
// Reset: asynchronous and active low; afterwards all four slice memories are zeroed, one word
// address a cycle, and stall stays high on the input until that pass has finished.
module event_slice_accumulate_window_read (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  esaw_pkg::event_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output esaw_pkg::result_t out_data_o
);

  // The design is split into a controller and a datapath. The datapath holds one memory per
  // slice, 128-bit words of 32 counts each, addressed by column and word index. On acceptance
  // every slice reads the word that holds the event row. In the next cycle the following word
  // is read while the first word is captured. In the UPDATE state the count is incremented in
  // the active slice and the word three slices ahead is written with zeros, while the second
  // word is captured. The window results are then selected from the captured double words.
  esaw_pkg::ctrl_cmd_t cmd;
  esaw_pkg::dp_stat_t  stat;

  esaw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  esaw_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* tb/sv/tb_event_slice_accumulate_window_read.sv */
`timescale 1ns / 1ps

module tb_event_slice_accumulate_window_read;

  // Column height padded to whole words, as the slice memories hold it.
  localparam int PADDED_ROWS = esaw_pkg::WORDS_PER_COL * esaw_pkg::PIXELS_PER_WORD;
  localparam int DIRECTED_ROWS = 18;
  localparam int RANDOM_PER_PHASE = 66;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int BURST_LEN = 18;
  // The slowest correct run, including the clearing pass after reset,
  // stays well inside this limit; this leaves a wide margin.
  localparam int CYCLE_LIMIT = 200000;

  typedef enum int {
    PH_STEADY,
    PH_SENDER_GAPS,
    PH_RECEIVER_STALLS,
    PH_BOTH_IDLE,
    PH_BACKPRESSURE,
    PH_COUNT
  } idle_phase_e;

  // One row of the directed table. When typed is set, every window pixel of
  // that event is known to read as zero and is written in here directly.
  typedef struct packed {
    logic [esaw_pkg::COL_BITS-1:0]   x;
    logic [esaw_pkg::ROW_BITS-1:0]   y;
    logic [esaw_pkg::SLICE_BITS-1:0] s;
    logic                            typed;
  } directed_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  esaw_pkg::event_t  in_data_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  esaw_pkg::result_t out_data_o;

  event_slice_accumulate_window_read dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #2 clk_i = ~clk_i;

  // Our own copy of the four slices of event counts.
  logic [esaw_pkg::PIXEL_BITS-1:0] pixel_counts [esaw_pkg::SLICE_COUNT][esaw_pkg::COLUMNS]
                                                [PADDED_ROWS];
  // Window results still owed by the block, oldest first.
  esaw_pkg::result_t window_expected [$];
  esaw_pkg::result_t oldest_window;

  int cycle_count = 0;
  int mismatches = 0;
  int events_sent = 0;
  int results_checked = 0;
  int nonzero_reads = 0;

  // Idle rates in percent, changed by the stimulus process right after a
  // rising edge and read by the drivers at falling edges.
  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  // The stimulus process bumps the request count to ask the output side for
  // one long hold-off; the output driver counts the hold itself.
  int hold_requests = 0;
  int holds_started = 0;
  int hold_left = 0;

  task automatic report_mismatch(string msg);
    mismatches++;
    $display("MISMATCH cycle %0d: %s", cycle_count, msg);
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want) begin
      report_mismatch($sformatf("%s got %0d expected %0d (window result %0d)",
                                name, got, want, results_checked));
    end
  endtask

  // Pixel p (0..63) of the double word {word, word+1} of one column. The
  // first word is the upper half, so p below 32 comes from the next word,
  // which reads as zero past the end of the column.
  function automatic logic [esaw_pkg::PIXEL_BITS-1:0] double_word_pixel(int slice, int col,
                                                                        int word, int p);
    int w;
    int sub;
    if (p < esaw_pkg::PIXELS_PER_WORD) begin
      w = word + 1;
      sub = p;
    end else begin
      w = word;
      sub = p - esaw_pkg::PIXELS_PER_WORD;
    end
    if (w >= esaw_pkg::WORDS_PER_COL) begin
      return '0;
    end
    return pixel_counts[slice][col][w * esaw_pkg::PIXELS_PER_WORD + sub];
  endfunction

  // Apply one accepted event to the slice copy and queue the eleven window
  // results it causes: increment, then read, then clear the word three
  // slices ahead.
  task automatic accumulate_event(esaw_pkg::event_t ev, bit typed,
                                  logic [esaw_pkg::PIXEL_BITS-1:0] typed_pix);
    int col;
    int row;
    int s;
    int s_ref;
    int s_tag;
    int s_clr;
    int word;
    int off;
    int p;
    bit in_range;
    esaw_pkg::result_t r;
    col = int'(ev.event_x);
    row = int'(ev.event_y);
    s = int'(ev.active_slice);
    s_ref = (s + 1) % esaw_pkg::SLICE_COUNT;
    s_tag = (s + 2) % esaw_pkg::SLICE_COUNT;
    s_clr = (s + 3) % esaw_pkg::SLICE_COUNT;
    word = row / esaw_pkg::PIXELS_PER_WORD;
    off = row % esaw_pkg::PIXELS_PER_WORD;
    in_range = (col < esaw_pkg::COLUMNS) && (row < esaw_pkg::ROWS);
    if (in_range) begin
      pixel_counts[s][col][row] = pixel_counts[s][col][row] + esaw_pkg::PIXEL_BITS'(1);
    end
    for (int i = 0; i < esaw_pkg::WINDOW_LEN; i++) begin
      p = (off + i) % (2 * esaw_pkg::PIXELS_PER_WORD);
      r.window_pos = i[3:0];
      r.ref_pixel = '0;
      r.tag_pixel = '0;
      if (typed) begin
        r.ref_pixel = typed_pix;
        r.tag_pixel = typed_pix;
      end else if (in_range) begin
        r.ref_pixel = double_word_pixel(s_ref, col, word, p);
        r.tag_pixel = double_word_pixel(s_tag, col, word, p);
      end
      r.last = (i == esaw_pkg::WINDOW_LEN - 1);
      window_expected.push_back(r);
    end
    if (in_range) begin
      for (int k = 0; k < esaw_pkg::PIXELS_PER_WORD; k++) begin
        pixel_counts[s_clr][col][word * esaw_pkg::PIXELS_PER_WORD + k] = '0;
      end
    end
  endtask

  // Offer one event and return at the rising edge that accepts it. The task
  // is entered just after a rising edge, so each falling edge sees exactly
  // one assignment to the valid line: it only drops during a gap, and stays
  // high from one event to the next when there is none.
  task automatic offer_event(esaw_pkg::event_t ev, bit typed,
                             logic [esaw_pkg::PIXEL_BITS-1:0] typed_pix);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= ev;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    accumulate_event(ev, typed, typed_pix);
    events_sent++;
  endtask

  // Directed table. Typed rows are the ones whose reads are plainly zero:
  // fresh slices right after reset, and a window that lies entirely in the
  // word past the end of the column.
  function automatic directed_row_t directed_row(int k);
    directed_row_t row;
    case (k)
      // Corners of the coordinate space with untouched slices.
      0:  row = '{8'd0,   8'd0,   2'd0, 1'b1};
      1:  row = '{8'd255, 8'd255, 2'd3, 1'b1};
      // Window starts on the first pixel of the last word: every position
      // reads the word past the column end.
      2:  row = '{8'd255, 8'd224, 2'd1, 1'b1};
      // Word boundaries of the row index.
      3:  row = '{8'd0,   8'd31,  2'd1, 1'b0};
      4:  row = '{8'd0,   8'd32,  2'd3, 1'b0};
      // Build counts in slice 0, read them back as the reference slice and
      // as the tag slice, then clear the word and read it again.
      5:  row = '{8'd10,  8'd37,  2'd0, 1'b0};
      6:  row = '{8'd10,  8'd37,  2'd0, 1'b0};
      7:  row = '{8'd10,  8'd38,  2'd0, 1'b0};
      8:  row = '{8'd10,  8'd62,  2'd3, 1'b0};
      9:  row = '{8'd10,  8'd62,  2'd2, 1'b0};
      10: row = '{8'd10,  8'd35,  2'd1, 1'b0};
      11: row = '{8'd10,  8'd62,  2'd3, 1'b0};
      // Last column, window straddling the end of the column.
      12: row = '{8'd255, 8'd250, 2'd0, 1'b0};
      // Half-range boundaries and alternating bit patterns on both coordinates.
      13: row = '{8'd128, 8'd127, 2'd2, 1'b0};
      14: row = '{8'd127, 8'd128, 2'd1, 1'b0};
      15: row = '{8'd85,  8'd170, 2'd2, 1'b0};
      16: row = '{8'd170, 8'd85,  2'd1, 1'b0};
      default: row = '{8'd255, 8'd255, 2'd3, 1'b0};
    endcase
    return row;
  endfunction

  // A random event in a few busy columns and row bands, so that counts pile
  // up and the read windows see them before they are cleared.
  function automatic esaw_pkg::event_t busy_event();
    esaw_pkg::event_t ev;
    int base;
    case ($urandom_range(0, 3))
      0: ev.event_x = 8'd0;
      1: ev.event_x = 8'd3;
      2: ev.event_x = 8'd252;
      default: ev.event_x = 8'd255;
    endcase
    case ($urandom_range(0, 3))
      0: base = 24;
      1: base = 120;
      2: base = 216;
      default: base = 248;
    endcase
    ev.event_y = 8'(base + $urandom_range(0, 15));
    ev.active_slice = 2'($urandom_range(0, esaw_pkg::SLICE_COUNT - 1));
    return ev;
  endfunction

  // Cycle counter and the overall timeout.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Output side: random stalls at the phase's rate, or one long hold-off
  // when asked, counted here cycle by cycle.
  always @(negedge clk_i) begin
    if (holds_started != hold_requests) begin
      holds_started = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Every accepted window result is compared with the oldest one owed.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (window_expected.size() == 0) begin
        report_mismatch($sformatf("window result with none expected, pos %0d",
                                  out_data_o.window_pos));
      end else begin
        oldest_window = window_expected.pop_front();
        check_field("window_pos", int'(out_data_o.window_pos),
                    int'(oldest_window.window_pos));
        check_field("ref_pixel", int'(out_data_o.ref_pixel), int'(oldest_window.ref_pixel));
        check_field("tag_pixel", int'(out_data_o.tag_pixel), int'(oldest_window.tag_pixel));
        check_field("last", int'(out_data_o.last), int'(oldest_window.last));
        if (oldest_window.ref_pixel != 0 || oldest_window.tag_pixel != 0) begin
          nonzero_reads++;
        end
      end
      results_checked++;
    end
  end

  initial begin
    directed_row_t row;
    esaw_pkg::event_t ev;
    esaw_pkg::event_t burst_ev;
    int burst_left;
    bit probe_due;
    int off;
    int back;
    int roll;
    idle_phase_e idle_phase;

    burst_left = 0;
    probe_due = 1'b0;
    for (int s = 0; s < esaw_pkg::SLICE_COUNT; s++) begin
      for (int c = 0; c < esaw_pkg::COLUMNS; c++) begin
        for (int r = 0; r < PADDED_ROWS; r++) begin
          pixel_counts[s][c][r] = '0;
        end
      end
    end

    // Reset once; the block then clears its memories with the input stalled,
    // which the first handshake simply waits out.
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, with no idling on either side.
    for (int k = 0; k < DIRECTED_ROWS; k++) begin
      row = directed_row(k);
      ev.event_x = row.x;
      ev.event_y = row.y;
      ev.active_slice = row.s;
      offer_event(ev, row.typed, '0);
    end

    // Random part, one block of events per idle pattern.
    for (int ph = 0; ph < PH_COUNT; ph++) begin
      idle_phase = idle_phase_e'(ph);
      case (idle_phase)
        PH_STEADY: begin
          sender_idle_pct = 0;
          recv_stall_pct = 0;
        end
        PH_SENDER_GAPS: begin
          sender_idle_pct = 46;
          recv_stall_pct = 0;
        end
        PH_RECEIVER_STALLS: begin
          sender_idle_pct = 0;
          recv_stall_pct = 46;
        end
        PH_BOTH_IDLE: begin
          sender_idle_pct = 26;
          recv_stall_pct = 26;
        end
        default: begin
          // The output holds off for a long stretch while events keep
          // coming, so the block fills and stalls its input.
          sender_idle_pct = 0;
          recv_stall_pct = 26;
          hold_requests++;
        end
      endcase

      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (burst_left > 0) begin
          // Same pixel over and over, so its count wraps past fifteen.
          burst_left--;
          ev = burst_ev;
          probe_due = (burst_left == 0);
        end else if (probe_due) begin
          // Read the wrapped pixel back: the probe sits one word lower with
          // the slice before, so the pixel shows up in the next-word half of
          // its window as the reference count.
          probe_due = 1'b0;
          off = int'(burst_ev.event_y) % esaw_pkg::PIXELS_PER_WORD;
          back = $urandom_range(0, 10);
          if (back > off) begin
            back = off;
          end
          ev.event_x = burst_ev.event_x;
          ev.event_y = burst_ev.event_y - 8'(esaw_pkg::PIXELS_PER_WORD) - 8'(back);
          ev.active_slice = burst_ev.active_slice - 2'd1;
        end else begin
          roll = $urandom_range(0, 99);
          if (roll < 4) begin
            burst_ev = busy_event();
            burst_left = BURST_LEN - 1;
            ev = burst_ev;
          end else if (roll < 72) begin
            ev = busy_event();
          end else begin
            ev.event_x = 8'($urandom_range(0, 255));
            ev.event_y = 8'($urandom_range(0, 255));
            ev.active_slice = 2'($urandom_range(0, esaw_pkg::SLICE_COUNT - 1));
          end
        end
        offer_event(ev, 1'b0, '0);
      end
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    sender_idle_pct = 0;

    // Drain what is still owed, then watch a little longer for strays.
    while (window_expected.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d events over five idle patterns, one with a long output hold.",
             events_sent);
    $display("Checked %0d window results, %0d of them with a nonzero count.",
             results_checked, nonzero_reads);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
